// File: rtl/laplace_edge_magnitude_3x3_macros.svh
// Assertion macros
`ifndef LAPLACE_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define LAPLACE_EDGE_MAGNITUDE_3X3_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LEM_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define LEM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define LEM_ASSERT_IMPL(label, clk, rst, prop)
`define LEM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: rtl/lem_pkg.sv
`default_nettype none
package lem_pkg;
   localparam int unsigned CFG_BITS = 11;
   localparam int PIXEL_BITS = 8;
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       last_pixel;
   } rsp_type;

   // one Laplacian evaluation, registered between stages
   typedef struct packed {
      logic [PIXEL_BITS-1:0] centre;
      logic [PIXEL_BITS-1:0] up;
      logic [PIXEL_BITS-1:0] down;
      logic [PIXEL_BITS-1:0] left;
      logic [PIXEL_BITS-1:0] right;
      logic        hu;
      logic        hd;
      logic        hl;
      logic        hr;
      logic        last;
   } lap_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } res_type;
endpackage
`default_nettype wire

// File: rtl/laplace_edge_magnitude_3x3.sv
// Pipeline: request registered with the line buffer reads, then operands registered.
// Throughput: one request per cycle; a pixel at the row end can yield two results,
// queued in an 8-entry output FIFO; input stalls while the FIFO could not take
// the stage-2 results in flight plus two for stage 1 and two for a new request.
// Reset: synchronous active high; counts and window clear, width 1024,
// line buffers are not cleared.
`default_nettype none
`include "laplace_edge_magnitude_3x3_macros.svh"
module laplace_edge_magnitude_3x3
   import lem_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire req_type       req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      rsp_type       rsp_data,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [CFG_BITS-1:0] csr_data
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PB = PIXEL_BITS;

   logic [PB-1:0] older_mem [MAX_WIDTH];
   logic [PB-1:0] prev_mem  [MAX_WIDTH];

   logic [CFG_BITS-1:0] width_ff;
   logic [AW:0]  width_eff;
   logic [AW:0]  col_ff, col_in;
   logic [10:0]  row_ff, row_in;
   logic [AW:0]  drain_ff, drain_in;
   logic [PB-1:0] win_ff [3][3];
   logic [PB-1:0] dcur_ff;

   // stage 1: request registered with memory reads
   logic        s1_ff;
   logic        s1_drain_ff;
   logic [PB-1:0] s1_pix_ff;
   logic [AW:0] s1_col_ff;
   logic [10:0] s1_row_ff;
   logic [AW:0] s1_width_ff;
   logic [PB-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic        s1_last_ff;

   // stage 2: two ops
   logic        op0_v_ff, op1_v_ff;
   lap_type     op0_ff, op1_ff, op0_in, op1_in;
   logic        op0_v_in, op1_v_in;
   res_type     r0, r1;

   // output fifo, 8 entries
   res_type     fifo_ff [8];
   logic [2:0]  wp_ff, rp_ff;
   logic [3:0]  cnt_ff;
   logic        accept, drain_ok, pix;
   logic [AW:0] c_use, rd_addr, nx_addr;
   logic [AW-1:0] rd_idx;
   logic [PB-1:0] a_w, b_w;
   logic [1:0]  push;

   always_comb begin
      if (width_ff == '0) width_eff = (AW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) width_eff = (AW+1)'(MAX_WIDTH);
      else width_eff = (AW+1)'(width_ff);
   end

   // allow in only when fifo can absorb everything in flight
   assign req_ready = (cnt_ff + {3'b0, op0_v_ff} + {3'b0, op1_v_ff} + {2'b0, s1_ff, 1'b0})
                      <= 4'd6;
   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;
   assign pix = req_data.action == ACTION_PIXEL;
   assign drain_ok = row_ff != '0 && col_ff == '0 && drain_ff < width_eff;
   assign c_use = (pix && drain_ff != '0) ? '0 : ((col_ff >= width_eff) ? '0 : col_ff);
   assign rd_addr = pix ? c_use : drain_ff;
   assign rd_idx = rd_addr[AW-1:0];
   assign nx_addr = drain_ff + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      drain_in = drain_ff;
      if (accept && pix) begin
         if (drain_ff != '0) row_in = '0;
         col_in = c_use + 1'b1;
         if (c_use + 1'b1 >= width_eff) begin
            col_in = '0;
            if (row_in != 11'd2047) row_in = row_in + 1'b1;
         end
         drain_in = '0;
      end else if (accept && drain_ok) begin
         if (drain_ff + 1'b1 >= width_eff) begin
            col_in = '0; row_in = '0; drain_in = '0;
         end else drain_in = drain_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      // older line write is issued from stage 1, behind the read; forward it to a read of the same entry
      if (s1_ff && !s1_drain_ff && s1_col_ff[AW-1:0] == rd_idx) rd_a_ff <= rd_b_ff;
      else rd_a_ff <= older_mem[rd_idx];
      rd_b_ff <= prev_mem[rd_idx];
      rd_c_ff <= prev_mem[nx_addr[AW-1:0]];
      if (s1_ff && !s1_drain_ff) older_mem[s1_col_ff[AW-1:0]] <= rd_b_ff;
      if (accept && pix) prev_mem[rd_idx] <= req_data.pixel_value[PB-1:0];
      s1_drain_ff <= !pix;
      s1_pix_ff <= req_data.pixel_value[PB-1:0];
      s1_col_ff <= pix ? c_use : drain_ff;
      s1_row_ff <= (pix && drain_ff != '0) ? '0 : row_ff;
      s1_width_ff <= width_eff;
      s1_last_ff <= drain_ff + 1'b1 >= width_eff;
   end

   always_comb begin
      a_w = rd_a_ff;
      b_w = rd_b_ff;
   end

   // window shift in stage 1 -> stage 2
   always_comb begin
      op0_in = '0; op1_in = '0; op0_v_in = 1'b0; op1_v_in = 1'b0;
      if (s1_ff && !s1_drain_ff) begin
         if (s1_row_ff >= 11'd1) begin
            if (s1_col_ff >= 1) begin
               op0_v_in = 1'b1;
               op0_in.centre = win_ff[1][2]; op0_in.up = win_ff[0][2];
               op0_in.down = win_ff[2][2]; op0_in.left = win_ff[1][1];
               op0_in.right = b_w;
               op0_in.hu = s1_row_ff >= 11'd2; op0_in.hd = 1'b1;
               op0_in.hl = s1_col_ff >= 2; op0_in.hr = 1'b1;
            end
            if (s1_col_ff + 1'b1 == s1_width_ff) begin
               op1_v_in = 1'b1;
               op1_in.centre = b_w; op1_in.up = a_w;
               op1_in.down = s1_pix_ff; op1_in.left = win_ff[1][2];
               op1_in.hu = s1_row_ff >= 11'd2; op1_in.hd = 1'b1;
               op1_in.hl = s1_col_ff >= 1; op1_in.hr = 1'b0;
            end
         end
      end else if (s1_ff) begin
         // drain: left is previous drain centre, right read from the next entry
         op0_v_in = 1'b1;
         op0_in.centre = b_w; op0_in.up = a_w;
         op0_in.left = dcur_ff;
         op0_in.right = rd_c_ff;
         op0_in.hu = s1_row_ff >= 11'd2; op0_in.hd = 1'b0;
         op0_in.hl = s1_col_ff > 0; op0_in.hr = (s1_col_ff + 1'b1) < s1_width_ff;
         op0_in.last = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) win_ff[r][k] <= '0;
         end
      end else if (s1_ff && !s1_drain_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= a_w; win_ff[1][2] <= b_w; win_ff[2][2] <= s1_pix_ff;
      end
      if (s1_ff && s1_drain_ff) dcur_ff <= b_w;
      op0_ff <= op0_in;
      op1_ff <= op1_in;
   end

   lem_calc u_calc0 (.op(op0_ff), .res(r0));
   lem_calc u_calc1 (.op(op1_ff), .res(r1));

   assign push = {1'b0, op0_v_ff} + {1'b0, op1_v_ff};
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data.edge_value = fifo_ff[rp_ff].value;
   assign rsp_data.last_pixel = fifo_ff[rp_ff].last;

   always_ff @(posedge clock) begin
      if (op0_v_ff) fifo_ff[wp_ff] <= r0;
      if (op1_v_ff) fifo_ff[op0_v_ff ? wp_ff + 3'd1 : wp_ff] <= r1;
      if (reset) begin
         width_ff <= CFG_BITS'(1024);
         col_ff <= '0; row_ff <= '0; drain_ff <= '0;
         s1_ff <= 1'b0; op0_v_ff <= 1'b0; op1_v_ff <= 1'b0;
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            width_ff <= csr_data;
            col_ff <= '0; row_ff <= '0; drain_ff <= '0;
         end else begin
            col_ff <= col_in; row_ff <= row_in; drain_ff <= drain_in;
         end
         s1_ff <= accept && (pix || drain_ok);
         op0_v_ff <= op0_v_in;
         op1_v_ff <= op1_v_in;
         wp_ff <= wp_ff + {1'b0, push};
         if (rsp_valid && rsp_ready) rp_ff <= rp_ff + 3'd1;
         cnt_ff <= cnt_ff + {2'b0, push} - {3'b0, rsp_valid && rsp_ready};
      end
   end

   `LEM_ASSERT_IMPL(a_fifo_bound, clock, reset, cnt_ff <= 4'd8)
   `LEM_ASSERT_NEXT(a_no_push_idle, clock, reset, !s1_ff, !op0_v_ff && !op1_v_ff)
endmodule
`default_nettype wire

// File: rtl/lem_calc.sv
`default_nettype none
module lem_calc
   import lem_pkg::*;
(
   input  wire lap_type op,
   output res_type      res
);
   localparam int SB = PIXEL_BITS + 3;
   localparam int NB = SB + 5;
   logic [SB-1:0] nsum, prod, mag;
   logic [2:0]    k;
   logic [3:0]    n;
   logic [NB+25:0] scaled;
   logic [NB-1:0] q;
   logic [25:0]   inv;
   logic [NB-1:0] num2;

   always_comb begin
      nsum = '0;
      k = '0;
      if (op.hu) begin nsum = nsum + SB'(op.up[PIXEL_BITS-1:0]); k = k + 3'd1; end
      if (op.hd) begin nsum = nsum + SB'(op.down[PIXEL_BITS-1:0]); k = k + 3'd1; end
      if (op.hl) begin nsum = nsum + SB'(op.left[PIXEL_BITS-1:0]); k = k + 3'd1; end
      if (op.hr) begin nsum = nsum + SB'(op.right[PIXEL_BITS-1:0]); k = k + 3'd1; end
      prod = SB'(k) * SB'(op.centre[PIXEL_BITS-1:0]);
      mag = (prod >= nsum) ? prod - nsum : nsum - prod;
      n = ({3'b0, op.hu} + {3'b0, op.hd} + 4'd1) * ({3'b0, op.hl} + {3'b0, op.hr} + 4'd1);
      num2 = NB'({mag, 1'b0}) + NB'(n);
      // rounded-up reciprocal of 2n, exact floor for numerators below 4096
      unique case (n)
         4'd1: inv = 26'd33554432;
         4'd2: inv = 26'd16777216;
         4'd3: inv = 26'd11184811;
         4'd4: inv = 26'd8388608;
         4'd6: inv = 26'd5592406;
         4'd9: inv = 26'd3728271;
         default: inv = 26'd33554432;
      endcase
      scaled = (NB+26)'(num2) * (NB+26)'(inv);
      q = scaled[NB+25:26];
   end

   assign res.value = (q > NB'(255)) ? 8'd255 : q[7:0];
   assign res.last = op.last;
endmodule
`default_nettype wire
